[rtl/kvrp_pkg.sv]
//------------------------------------------------------------------------------
// kvrp_pkg
// Shared types, constants and helpers of the key/value record parser.
//------------------------------------------------------------------------------
`default_nettype none

package kvrp_pkg;

	// Default table geometry.
	localparam int MAX_FIELDS_DEF = 32;
	localparam int NAME_MAX_DEF   = 31;
	localparam int VALUE_MAX_DEF  = 127;

	// Record syntax characters.
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_RBR = 8'h5D;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NOP  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_ADDED   = 3'd0,
		EV_REPEAT  = 3'd1,
		EV_REC_END = 3'd2,
		EV_ERROR   = 3'd3,
		EV_READ    = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_BAD_CHAR = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		PH_NEW   = 2'd0,
		PH_NAME  = 2'd1,
		PH_VALUE = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_OUT,
		ST_CMT,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_ADD,
		ST_DUP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic   capture;
		logic   count_clr;
		logic   nlen_clr;
		logic   vlen_clr;
		logic   cur_clr;
		logic   name_wr;
		logic   value_wr;
		logic   trunc_set;
		logic   add;
		logic   walk_clr;
		logic   walk_inc;
		logic   chr_clr;
		logic   chr_inc;
		logic   cmp_sel;
		logic   emit;
		event_t ev;
		err_t   err;
		logic   done;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  last;
		logic  is_eq;
		logic  is_bar;
		logic  is_name;
		logic  nlen_zero;
		logic  nlen_full;
		logic  vlen_full;
		logic  drop_on;
		logic  count_zero;
		logic  full_after_add;
		logic  full_now;
		logic  len_match;
		logic  chr_match;
		logic  chr_last;
		logic  walk_last;
	} dp_stat_t;

	// Letters, digits, dot and square brackets may form a name.
	function automatic logic is_name_char(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"], ["0":"9"], CH_DOT, CH_LBR, CH_RBR};
	endfunction

endpackage

`default_nettype wire

[rtl/kvrp_datapath.sv]
//------------------------------------------------------------------------------
// kvrp_datapath
// Item capture, parse counters, name/value/length stores, duplicate-name
// compare and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module kvrp_datapath #(
	parameter int MAX_FIELDS = kvrp_pkg::MAX_FIELDS_DEF,
	parameter int NAME_MAX   = kvrp_pkg::NAME_MAX_DEF,
	parameter int VALUE_MAX  = kvrp_pkg::VALUE_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  kvrp_pkg::dp_cmd_t      cmd,
	output kvrp_pkg::dp_stat_t     stat,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last,
	input  wire logic [4:0]        read_slot,
	input  wire logic              read_value_part,
	input  wire logic [6:0]        read_pos,
	input  wire logic              cfg_we,
	input  wire logic              cfg_data,
	output logic                   strobe,
	output logic [2:0]             event_res,
	output logic [1:0]             error_code,
	output logic [4:0]             field_slot,
	output logic [5:0]             field_count,
	output logic [4:0]             name_length,
	output logic [6:0]             value_length,
	output logic                   value_truncated,
	output logic [7:0]             read_char,
	output logic                   done_res
);

	localparam int SW     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CW     = $clog2(MAX_FIELDS + 1);
	localparam int NW     = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int VW     = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
	localparam int NLW    = $clog2(NAME_MAX + 1);
	localparam int VLW    = $clog2(VALUE_MAX + 1);
	localparam int NDEPTH = MAX_FIELDS * (2 ** NW);
	localparam int VDEPTH = MAX_FIELDS * (2 ** VW);

	// Captured item.
	kvrp_pkg::kind_t kind_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic [4:0]      rslot_q;
	logic            rpart_q;
	logic [6:0]      rpos_q;

	// Parse state.
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_d;
	logic [NLW-1:0]  nlen_q;
	logic [VLW-1:0]  vlen_q;
	logic            trunc_q;
	logic            drop_q;
	logic [SW-1:0]   walk_q;
	logic [NW-1:0]   chr_q;
	logic [7:0]      cur_name_q [NAME_MAX];

	// Stores.
	logic [7:0]      name_mem  [NDEPTH];
	logic [7:0]      value_mem [VDEPTH];
	logic [NLW-1:0]  nlen_mem  [MAX_FIELDS];
	logic [VLW-1:0]  vlen_mem  [MAX_FIELDS];
	logic [7:0]      name_rd_q;
	logic [7:0]      value_rd_q;
	logic [NLW-1:0]  nlen_rd_q;
	logic [VLW-1:0]  vlen_rd_q;

	logic [31:0]        rslot_w;
	logic [31:0]        rpos_w;
	logic [SW+NW-1:0]   name_waddr;
	logic [SW+NW-1:0]   name_raddr;
	logic [SW+VW-1:0]   value_addr;
	logic [SW-1:0]      len_raddr;
	logic               rd_ok;

	// Capture the item at acceptance.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kvrp_pkg::kind_t'(kind);
			byte_q  <= data_byte;
			last_q  <= last;
			rslot_q <= read_slot;
			rpart_q <= read_value_part;
			rpos_q  <= read_pos;
		end
	end

	// Field count of the table after the current command.
	always_comb begin
		if (cmd.count_clr) begin
			cnt_d = '0;
		end else if (cmd.add) begin
			cnt_d = cnt_q + CW'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	// Counters and the repeat-drop register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			nlen_q  <= '0;
			vlen_q  <= '0;
			trunc_q <= 1'b0;
			drop_q  <= 1'b1;
			walk_q  <= '0;
			chr_q   <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.nlen_clr || cmd.cur_clr) begin
				nlen_q <= '0;
			end else if (cmd.name_wr) begin
				nlen_q <= nlen_q + NLW'(1);
			end
			if (cmd.vlen_clr || cmd.cur_clr) begin
				vlen_q  <= '0;
				trunc_q <= 1'b0;
			end else begin
				if (cmd.value_wr) begin
					vlen_q <= vlen_q + VLW'(1);
				end
				if (cmd.trunc_set) begin
					trunc_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				drop_q <= cfg_data;
			end
			if (cmd.walk_clr) begin
				walk_q <= '0;
			end else if (cmd.walk_inc) begin
				walk_q <= walk_q + SW'(1);
			end
			if (cmd.chr_clr) begin
				chr_q <= '0;
			end else if (cmd.chr_inc) begin
				chr_q <= chr_q + NW'(1);
			end
		end
	end

	// Copy of the name being built, used by the repeat compare.
	always_ff @(posedge clk) begin
		if (cmd.name_wr) begin
			cur_name_q[nlen_q[NW-1:0]] <= byte_q;
		end
	end

	// Store addressing: each slot owns a power-of-two row of characters.
	assign rslot_w    = 32'(rslot_q);
	assign rpos_w     = 32'(rpos_q);
	assign name_waddr = {cnt_q[SW-1:0], nlen_q[NW-1:0]};
	assign name_raddr = cmd.cmp_sel ? {walk_q, chr_q} : {rslot_w[SW-1:0], rpos_w[NW-1:0]};
	assign value_addr = cmd.value_wr ? {cnt_q[SW-1:0], vlen_q[VW-1:0]}
	                                 : {rslot_w[SW-1:0], rpos_w[VW-1:0]};
	assign len_raddr  = cmd.cmp_sel ? walk_q : rslot_w[SW-1:0];

	// Name store.
	always_ff @(posedge clk) begin
		if (cmd.name_wr) begin
			name_mem[name_waddr] <= byte_q;
		end
		name_rd_q <= name_mem[name_raddr];
	end

	// Value store.
	always_ff @(posedge clk) begin
		if (cmd.value_wr) begin
			value_mem[value_addr] <= byte_q;
		end
		value_rd_q <= value_mem[value_addr];
	end

	// Length stores, written when a field is added.
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			nlen_mem[cnt_q[SW-1:0]] <= nlen_q;
			vlen_mem[cnt_q[SW-1:0]] <= vlen_q;
		end
		nlen_rd_q <= nlen_mem[len_raddr];
		vlen_rd_q <= vlen_mem[len_raddr];
	end

	// Status toward the controller.
	always_comb begin
		stat.kind           = kind_q;
		stat.last           = last_q;
		stat.is_eq          = (byte_q == kvrp_pkg::CH_EQ);
		stat.is_bar         = (byte_q == kvrp_pkg::CH_BAR);
		stat.is_name        = kvrp_pkg::is_name_char(byte_q);
		stat.nlen_zero      = (nlen_q == '0);
		stat.nlen_full      = (32'(nlen_q) >= NAME_MAX);
		stat.vlen_full      = (32'(vlen_q) >= VALUE_MAX);
		stat.drop_on        = drop_q;
		stat.count_zero     = (cnt_q == '0);
		stat.full_after_add = (32'(cnt_q) + 32'd1 >= MAX_FIELDS);
		stat.full_now       = (32'(cnt_q) >= MAX_FIELDS);
		stat.len_match      = (nlen_rd_q == nlen_q);
		stat.chr_match      = (name_rd_q == cur_name_q[chr_q]);
		stat.chr_last       = (32'(chr_q) + 32'd1 == 32'(nlen_q));
		stat.walk_last      = (32'(walk_q) + 32'd1 == 32'(cnt_q));
	end

	// A read returns a character only inside a stored field.
	always_comb begin
		if (rpart_q) begin
			rd_ok = (rslot_w < 32'(cnt_q)) && (rpos_w < 32'(vlen_rd_q)) &&
			        (rpos_w < VALUE_MAX);
		end else begin
			rd_ok = (rslot_w < 32'(cnt_q)) && (rpos_w < 32'(nlen_rd_q)) &&
			        (rpos_w < NAME_MAX);
		end
	end

	// Result register, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			event_res       <= cmd.ev;
			error_code      <= cmd.err;
			field_count     <= 6'(cnt_d);
			done_res        <= cmd.done;
			field_slot      <= '0;
			name_length     <= '0;
			value_length    <= '0;
			value_truncated <= 1'b0;
			read_char       <= '0;
			case (cmd.ev)
				kvrp_pkg::EV_ADDED, kvrp_pkg::EV_REPEAT: begin
					field_slot      <= (cmd.ev == kvrp_pkg::EV_ADDED) ? 5'(cnt_q) : 5'(walk_q);
					name_length     <= 5'(nlen_q);
					value_length    <= 7'(vlen_q);
					value_truncated <= trunc_q;
				end
				kvrp_pkg::EV_READ: begin
					read_char <= rd_ok ? (rpart_q ? value_rd_q : name_rd_q) : 8'h00;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/kvrp_ctrl.sv]
//------------------------------------------------------------------------------
// kvrp_ctrl
// Parse state machine: decodes each item, sequences the commit and the
// repeat-name walk, and orders the datapath by commands.
//------------------------------------------------------------------------------
`default_nettype none

module kvrp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  kvrp_pkg::dp_stat_t stat,
	output kvrp_pkg::dp_cmd_t  cmd
);

	kvrp_pkg::state_t state_q, state_d;
	kvrp_pkg::phase_t phase_q, phase_d;
	logic             cmt_last_q, cmt_last_d;
	logic             rec_end;
	logic             rec_done;
	logic             err_hit;
	kvrp_pkg::err_t   err_c;
	logic             end_seq;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kvrp_pkg::ST_IDLE;
			phase_q    <= kvrp_pkg::PH_NEW;
			cmt_last_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			cmt_last_q <= cmt_last_d;
		end
	end

	assign busy = (state_q != kvrp_pkg::ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		cmt_last_d = cmt_last_q;
		cmd        = '0;
		rec_end    = 1'b0;
		rec_done   = 1'b0;
		err_hit    = 1'b0;
		err_c      = kvrp_pkg::ERR_NONE;
		end_seq    = cmt_last_q;

		case (state_q)
			kvrp_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = kvrp_pkg::ST_EXEC;
				end
			end

			kvrp_pkg::ST_EXEC: begin
				state_d = kvrp_pkg::ST_IDLE;
				case (stat.kind)
					kvrp_pkg::KIND_READ: begin
						state_d = kvrp_pkg::ST_RD_OUT;
					end
					kvrp_pkg::KIND_END: begin
						case (phase_q)
							kvrp_pkg::PH_NEW: begin
								cmd.count_clr = 1'b1;
								rec_end       = 1'b1;
								rec_done      = 1'b1;
							end
							kvrp_pkg::PH_VALUE: begin
								cmt_last_d = 1'b1;
								state_d    = kvrp_pkg::ST_CMT;
							end
							kvrp_pkg::PH_NAME: begin
								rec_end  = 1'b1;
								rec_done = 1'b1;
							end
							default: begin
								rec_end = 1'b1;
							end
						endcase
					end
					kvrp_pkg::KIND_BYTE: begin
						case (phase_q)
							// First byte of a record empties the table.
							kvrp_pkg::PH_NEW: begin
								cmd.count_clr = 1'b1;
								cmd.nlen_clr  = 1'b1;
								cmd.vlen_clr  = 1'b1;
								phase_d       = kvrp_pkg::PH_NAME;
								state_d       = kvrp_pkg::ST_EXEC;
							end
							kvrp_pkg::PH_SKIP: begin
								rec_end = stat.last;
							end
							kvrp_pkg::PH_NAME: begin
								if (stat.is_eq) begin
									if (stat.nlen_zero) begin
										rec_end  = stat.last;
										rec_done = 1'b1;
									end else begin
										phase_d      = kvrp_pkg::PH_VALUE;
										cmd.vlen_clr = 1'b1;
										if (stat.last) begin
											cmt_last_d = 1'b1;
											state_d    = kvrp_pkg::ST_CMT;
										end
									end
								end else if (stat.is_name) begin
									if (stat.nlen_full) begin
										err_hit = 1'b1;
										err_c   = kvrp_pkg::ERR_TOO_LONG;
									end else begin
										cmd.name_wr = 1'b1;
										rec_end     = stat.last;
										rec_done    = 1'b1;
									end
								end else if (stat.is_bar) begin
									cmd.nlen_clr = 1'b1;
									rec_end      = stat.last;
									rec_done     = 1'b1;
								end else begin
									err_hit = 1'b1;
									err_c   = kvrp_pkg::ERR_BAD_CHAR;
								end
							end
							default: begin
								// Value phase.
								if (stat.is_bar) begin
									cmt_last_d = stat.last;
									state_d    = kvrp_pkg::ST_CMT;
								end else begin
									if (stat.vlen_full) begin
										cmd.trunc_set = 1'b1;
									end else begin
										cmd.value_wr = 1'b1;
									end
									if (stat.last) begin
										cmt_last_d = 1'b1;
										state_d    = kvrp_pkg::ST_CMT;
									end
								end
							end
						endcase
					end
					default: begin
					end
				endcase
			end

			kvrp_pkg::ST_RD_OUT: begin
				cmd.emit = 1'b1;
				cmd.ev   = kvrp_pkg::EV_READ;
				state_d  = kvrp_pkg::ST_IDLE;
			end

			// Commit: walk stored names only when repeats are dropped.
			kvrp_pkg::ST_CMT: begin
				if (stat.drop_on && !stat.count_zero) begin
					cmd.walk_clr = 1'b1;
					cmd.chr_clr  = 1'b1;
					state_d      = kvrp_pkg::ST_WALK_RD;
				end else begin
					state_d = kvrp_pkg::ST_ADD;
				end
			end

			kvrp_pkg::ST_WALK_RD: begin
				cmd.cmp_sel = 1'b1;
				state_d     = kvrp_pkg::ST_WALK_CMP;
			end

			kvrp_pkg::ST_WALK_CMP: begin
				if (stat.len_match && stat.chr_match) begin
					if (stat.chr_last) begin
						state_d = kvrp_pkg::ST_DUP;
					end else begin
						cmd.chr_inc = 1'b1;
						state_d     = kvrp_pkg::ST_WALK_RD;
					end
				end else if (stat.walk_last) begin
					state_d = kvrp_pkg::ST_ADD;
				end else begin
					cmd.walk_inc = 1'b1;
					cmd.chr_clr  = 1'b1;
					state_d      = kvrp_pkg::ST_WALK_RD;
				end
			end

			kvrp_pkg::ST_ADD, kvrp_pkg::ST_DUP: begin
				cmd.cur_clr = 1'b1;
				cmd.emit    = 1'b1;
				if (state_q == kvrp_pkg::ST_ADD) begin
					cmd.add = 1'b1;
					cmd.ev  = kvrp_pkg::EV_ADDED;
					end_seq = stat.full_after_add;
				end else begin
					cmd.ev  = kvrp_pkg::EV_REPEAT;
					end_seq = stat.full_now;
				end
				if (cmt_last_q) begin
					cmd.done = 1'b1;
					phase_d  = kvrp_pkg::PH_NEW;
				end else if (end_seq) begin
					cmd.done = 1'b1;
					phase_d  = kvrp_pkg::PH_SKIP;
				end else begin
					phase_d  = kvrp_pkg::PH_NAME;
				end
				state_d = kvrp_pkg::ST_IDLE;
			end

			default: begin
				state_d = kvrp_pkg::ST_IDLE;
			end
		endcase

		// Record end and error reports share their bookkeeping.
		if (rec_end) begin
			cmd.emit     = 1'b1;
			cmd.ev       = kvrp_pkg::EV_REC_END;
			cmd.done     = rec_done;
			cmd.nlen_clr = 1'b1;
			phase_d      = kvrp_pkg::PH_NEW;
		end
		if (err_hit) begin
			cmd.emit     = 1'b1;
			cmd.ev       = kvrp_pkg::EV_ERROR;
			cmd.err      = err_c;
			cmd.done     = 1'b1;
			cmd.nlen_clr = 1'b1;
			phase_d      = stat.last ? kvrp_pkg::PH_NEW : kvrp_pkg::PH_SKIP;
		end
	end

endmodule

`default_nettype wire

[rtl/key_value_record_parser.sv]
// A record byte is captured while idle, then decoded in the execute state, twice for a
// record's first byte; a read adds the read-out state. A commit adds the commit and add or
// repeat states and, with repeat dropping on, a read and a compare state per compared
// stored length or name character via the single name-store read port. One item is in flight
// at a time; busy is high until it is done. Each result shows for one cycle on strobe; the
// receiver cannot stall. Reset clears control and parse state; stores need no clearing pass.
//------------------------------------------------------------------------------
// key_value_record_parser
// Parses name=value| record bytes into a field table and reports each field.
//------------------------------------------------------------------------------
`default_nettype none

module key_value_record_parser #(
	parameter int MAX_FIELDS = kvrp_pkg::MAX_FIELDS_DEF,
	parameter int NAME_MAX   = kvrp_pkg::NAME_MAX_DEF,
	parameter int VALUE_MAX  = kvrp_pkg::VALUE_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	input  wire logic [4:0] read_slot,
	input  wire logic       read_value_part,
	input  wire logic [6:0] read_pos,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	output logic            strobe,
	output logic [2:0]      event_res,
	output logic [1:0]      error_code,
	output logic [4:0]      field_slot,
	output logic [5:0]      field_count,
	output logic [4:0]      name_length,
	output logic [6:0]      value_length,
	output logic            value_truncated,
	output logic [7:0]      read_char,
	output logic            done_res
);

	kvrp_pkg::dp_cmd_t  cmd;
	kvrp_pkg::dp_stat_t stat;

	// The register accepts a write at any time.
	assign cfg_ready = 1'b1;

	kvrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	kvrp_datapath #(
		.MAX_FIELDS (MAX_FIELDS),
		.NAME_MAX   (NAME_MAX),
		.VALUE_MAX  (VALUE_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.data_byte       (data_byte),
		.last            (last),
		.read_slot       (read_slot),
		.read_value_part (read_value_part),
		.read_pos        (read_pos),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.event_res       (event_res),
		.error_code      (error_code),
		.field_slot      (field_slot),
		.field_count     (field_count),
		.name_length     (name_length),
		.value_length    (value_length),
		.value_truncated (value_truncated),
		.read_char       (read_char),
		.done_res        (done_res)
	);

endmodule

`default_nettype wire

[rtl/kvrp_checker.sv]
//------------------------------------------------------------------------------
// kvrp_checker
// Port-level checks of the record parser, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module kvrp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [2:0] event_res,
	input wire logic [1:0] error_code,
	input wire logic       done_res
);

	// An accepted item always raises busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result is issued only once the block has finished its item.
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while busy");

	// At most one result per item, so strobes never come back to back.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back results");

	// An error always ends parsing and carries a code.
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (event_res == kvrp_pkg::EV_ERROR) |->
			done_res && (error_code != kvrp_pkg::ERR_NONE))
		else $error("error result without code or done");

	// Non-error results carry no error code.
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (event_res != kvrp_pkg::EV_ERROR) |-> (error_code == kvrp_pkg::ERR_NONE))
		else $error("error code on a non-error result");

endmodule

bind key_value_record_parser kvrp_checker u_kvrp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.event_res  (event_res),
	.error_code (error_code),
	.done_res   (done_res)
);

`default_nettype wire
